[hw/rtl/csp_pkg.sv]
// ----------------------------------------------------------------------------
// csp_pkg
// Shared constants, types and helpers for the cave smoothing pass core.
// ----------------------------------------------------------------------------
package csp_pkg;

   localparam int MAX_WIDTH    = 256;
   localparam int COL_W        = $clog2(MAX_WIDTH);
   localparam int EFF_W_W      = COL_W + 1;
   localparam int WIDTH_REG_W  = 9;
   localparam int HEIGHT_REG_W = 13;
   localparam int ROW_CNT_W    = 13;
   localparam int HEIGHT_CAP   = 4096;
   localparam int LIMIT_W      = 4;
   localparam int COUNT_W      = 4;
   localparam int OUT_COL_W    = 8;
   localparam int OUT_ROW_W    = 12;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 13;
   localparam int WIN_W        = 9;
   localparam int LINE_W       = 2;
   localparam int QUEUE_DEPTH  = 4;
   localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CSR_INDEX_W-1:0] REG_GRID_WIDTH     = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_GRID_HEIGHT    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_BIRTH_LIMIT    = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_SURVIVAL_LIMIT = 2'd3;

   localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET    = 9'd64;
   localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET   = 13'd64;
   localparam logic [LIMIT_W-1:0]      BIRTH_RESET    = 4'd4;
   localparam logic [LIMIT_W-1:0]      SURVIVAL_RESET = 4'd3;

   localparam logic [WIN_W-1:0] ALL_WALL       = 9'h1FF;
   localparam logic [WIN_W-1:0] KEEP_LEFT_TWO  = 9'h0DB;
   localparam logic [WIN_W-1:0] RIGHT_OUTSIDE  = 9'h124;
   localparam logic [WIN_W-1:0] NEIGHBOUR_MASK = 9'h1EF;

   typedef struct packed {
      logic [EFF_W_W-1:0]   width;
      logic [ROW_CNT_W-1:0] height;
   } geom_cfg_type;

   typedef struct packed {
      logic [LIMIT_W-1:0] birth;
      logic [LIMIT_W-1:0] survival;
   } limit_cfg_type;

   typedef struct packed {
      logic                 valid;
      logic [COL_W-1:0]     col;
      logic                 top_en;
      logic                 mid_en;
      logic                 bot;
      logic                 col_zero;
      logic                 hazard;
      logic                 res_valid;
      logic [OUT_ROW_W-1:0] orow;
      logic [OUT_COL_W-1:0] ocol;
      logic                 last;
   } stage_item_type;

   typedef struct packed {
      logic                 new_is_wall;
      logic [OUT_COL_W-1:0] out_column;
      logic [OUT_ROW_W-1:0] out_row;
      logic                 frame_last;
   } result_type;

   function automatic logic [COUNT_W-1:0] wall_count(input logic [WIN_W-1:0] win);
      logic [WIN_W-1:0]   v;
      logic [COUNT_W-1:0] n;
      v = win & NEIGHBOUR_MASK;
      n = '0;
      for (int i = 0; i < WIN_W; i++) begin
         n = n + COUNT_W'(v[i]);
      end
      return n;
   endfunction

endpackage

[hw/rtl/csp_req_if.sv]
// ----------------------------------------------------------------------------
// csp_req_if
// Cell request channel: valid/ready handshake with command and cell value.
// ----------------------------------------------------------------------------
interface csp_req_if;
   logic valid;
   logic ready;
   logic command;
   logic cell_is_wall;

   modport source (output valid, output command, output cell_is_wall, input ready);
   modport sink   (input valid, input command, input cell_is_wall, output ready);
endinterface

[hw/rtl/csp_rsp_if.sv]
// ----------------------------------------------------------------------------
// csp_rsp_if
// Smoothed cell response channel: valid/ready handshake with result fields.
// ----------------------------------------------------------------------------
interface csp_rsp_if
   import csp_pkg::*;
;
   logic                 valid;
   logic                 ready;
   logic                 new_is_wall;
   logic [OUT_COL_W-1:0] out_column;
   logic [OUT_ROW_W-1:0] out_row;
   logic                 frame_last;

   modport source (output valid, output new_is_wall, output out_column, output out_row,
                   output frame_last, input ready);
   modport sink   (input valid, input new_is_wall, input out_column, input out_row,
                   input frame_last, output ready);
endinterface

[hw/rtl/csp_ram.sv]
// ----------------------------------------------------------------------------
// csp_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module csp_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/csp_front.sv]
// ----------------------------------------------------------------------------
// csp_front
// Accepts cells, tracks raster position, classifies each transaction and
// issues the line store read for it.
// ----------------------------------------------------------------------------
module csp_front
   import csp_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   csp_req_if.sink            req_chan,
   input  geom_cfg_type       geom,
   input  logic               restart,
   input  logic [QCNT_W-1:0]  queue_level,
   output stage_item_type     item,
   output logic [COL_W-1:0]   rd_addr
);

   logic [COL_W-1:0]     col_ff, col_in;
   logic [ROW_CNT_W-1:0] row_ff, row_in;
   stage_item_type       item_ff, item_in;

   logic                 accept;
   logic                 col_zero;
   logic                 top_en;
   logic                 mid_en;
   logic                 bot;
   logic [ROW_CNT_W-1:0] res_row;
   logic [COL_W-1:0]     res_col;
   logic                 res_valid;
   logic                 last;
   logic [EFF_W_W-1:0]   col_plus;

   assign req_chan.ready = (queue_level + QCNT_W'(item_ff.valid)) < QCNT_W'(QUEUE_DEPTH);

   always_comb begin
      accept    = req_chan.valid & req_chan.ready;
      col_zero  = (col_ff == '0);
      top_en    = (row_ff >= ROW_CNT_W'(2));
      mid_en    = (row_ff != '0);
      bot       = (!req_chan.command && (row_ff < geom.height)) ? req_chan.cell_is_wall : 1'b1;
      res_row   = col_zero ? (row_ff - ROW_CNT_W'(2)) : (row_ff - ROW_CNT_W'(1));
      res_col   = col_zero ? COL_W'(geom.width - EFF_W_W'(1)) : (col_ff - COL_W'(1));
      res_valid = (col_zero ? top_en : mid_en) && (res_row < geom.height);
      last      = res_valid && (res_row == (geom.height - ROW_CNT_W'(1)))
                  && (EFF_W_W'(res_col) == (geom.width - EFF_W_W'(1)));
      col_plus  = EFF_W_W'(col_ff) + EFF_W_W'(1);

      col_in = col_ff;
      row_in = row_ff;
      if (restart) begin
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (last) begin
            col_in = '0;
            row_in = '0;
         end else if (col_plus >= geom.width) begin
            col_in = '0;
            row_in = row_ff + ROW_CNT_W'(1);
         end else begin
            col_in = COL_W'(col_plus);
         end
      end

      item_in.valid     = accept;
      item_in.col       = col_ff;
      item_in.top_en    = top_en;
      item_in.mid_en    = mid_en;
      item_in.bot       = bot;
      item_in.col_zero  = col_zero;
      item_in.hazard    = item_ff.valid && (item_ff.col == col_ff);
      item_in.res_valid = res_valid;
      item_in.orow      = OUT_ROW_W'(res_row);
      item_in.ocol      = OUT_COL_W'(res_col);
      item_in.last      = last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff        <= '0;
         row_ff        <= '0;
         item_ff.valid <= 1'b0;
      end else begin
         col_ff        <= col_in;
         row_ff        <= row_in;
         item_ff.valid <= item_in.valid;
      end
      item_ff.col       <= item_in.col;
      item_ff.top_en    <= item_in.top_en;
      item_ff.mid_en    <= item_in.mid_en;
      item_ff.bot       <= item_in.bot;
      item_ff.col_zero  <= item_in.col_zero;
      item_ff.hazard    <= item_in.hazard;
      item_ff.res_valid <= item_in.res_valid;
      item_ff.orow      <= item_in.orow;
      item_ff.ocol      <= item_in.ocol;
      item_ff.last      <= item_in.last;
   end

   assign item    = item_ff;
   assign rd_addr = col_ff;

`ifndef SYNTHESIS
   a_col_in_row: assert property (@(posedge clock) disable iff (reset)
      EFF_W_W'(col_ff) < geom.width)
      else $error("column counter outside the grid width");

   a_row_bounded: assert property (@(posedge clock) disable iff (reset)
      row_ff <= (geom.height + ROW_CNT_W'(1)))
      else $error("row counter ran past the drain rows");
`endif

endmodule

[hw/rtl/csp_back.sv]
// ----------------------------------------------------------------------------
// csp_back
// Builds the 3x3 window from line store data, updates the line stores,
// counts wall neighbours and applies the birth and survival limits.
// ----------------------------------------------------------------------------
module csp_back
   import csp_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  stage_item_type     item,
   input  limit_cfg_type      limits,
   input  logic               restart,
   input  logic [LINE_W-1:0]  rd_data,
   output logic               wr_en,
   output logic [COL_W-1:0]   wr_addr,
   output logic [LINE_W-1:0]  wr_data,
   output logic               push,
   output result_type         push_data
);

   logic [WIN_W-1:0]  window_ff, window_in;
   logic [LINE_W-1:0] fwd_ff, fwd_in;

   logic [LINE_W-1:0]  line;
   logic               top;
   logic               mid;
   logic [WIN_W-1:0]   newcol;
   logic [WIN_W-1:0]   shifted;
   logic [WIN_W-1:0]   win_next;
   logic [WIN_W-1:0]   evalwin;
   logic [COUNT_W-1:0] walls;
   logic               wall;

   always_comb begin
      line     = item.hazard ? fwd_ff : rd_data;
      top      = item.top_en ? line[1] : 1'b1;
      mid      = item.mid_en ? line[0] : 1'b1;
      newcol   = {item.bot, 2'b00, mid, 2'b00, top, 2'b00};
      shifted  = (window_ff >> 1) & KEEP_LEFT_TWO;
      if (item.col_zero) begin
         evalwin  = shifted | RIGHT_OUTSIDE;
         win_next = KEEP_LEFT_TWO | newcol;
      end else begin
         win_next = shifted | newcol;
         evalwin  = win_next;
      end

      window_in = window_ff;
      if (restart) begin
         window_in = ALL_WALL;
      end else if (item.valid) begin
         window_in = item.last ? ALL_WALL : win_next;
      end

      fwd_in  = item.valid ? {mid, item.bot} : fwd_ff;
      wr_en   = item.valid;
      wr_addr = item.col;
      wr_data = {mid, item.bot};

      walls = wall_count(evalwin);
      wall  = evalwin[4] ? (walls >= limits.survival) : (walls >= limits.birth);

      push                  = item.valid & item.res_valid;
      push_data.new_is_wall = wall;
      push_data.out_column  = item.ocol;
      push_data.out_row     = item.orow;
      push_data.frame_last  = item.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= ALL_WALL;
      end else begin
         window_ff <= window_in;
      end
      fwd_ff <= fwd_in;
   end

endmodule

[hw/rtl/csp_queue.sv]
// ----------------------------------------------------------------------------
// csp_queue
// Short result queue between the window logic and the response channel.
// ----------------------------------------------------------------------------
module csp_queue
   import csp_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  result_type         push_data,
   output logic [QCNT_W-1:0]  level,
   csp_rsp_if.source          rsp_chan
);

   result_type          data_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                pop;
   result_type          head;

   always_comb begin
      head = data_ff[rd_ptr_ff];
      pop  = rsp_chan.valid & rsp_chan.ready;

      wr_ptr_in = push ? (wr_ptr_ff + QPTR_W'(1)) : wr_ptr_ff;
      rd_ptr_in = pop  ? (rd_ptr_ff + QPTR_W'(1)) : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         data_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign level                = count_ff;
   assign rsp_chan.valid       = (count_ff != '0);
   assign rsp_chan.new_is_wall = head.new_is_wall;
   assign rsp_chan.out_column  = head.out_column;
   assign rsp_chan.out_row     = head.out_row;
   assign rsp_chan.frame_last  = head.frame_last;

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff < QCNT_W'(QUEUE_DEPTH)))
      else $error("result pushed into a full queue");
`endif

endmodule

[hw/rtl/cave_automaton_smoothing_pass_core.sv]
// ----------------------------------------------------------------------------
// cave_automaton_smoothing_pass_core
// One smoothing pass of a wall/floor cellular automaton over a raster stream.
// ----------------------------------------------------------------------------
// Takes one cell per clock unless stalled and gives at most one smoothed cell
// per clock. Each result belongs to the cell one row plus one cell earlier in
// the input, so width+1 drain transactions after the last cell flush a frame.
// A result goes via the front item register and a queue entry to the response
// channel. The two line stores share one RAM read and written once per
// transaction, with a bypass for back-to-back access to the same column.
// Input stalls only when the four-entry result queue plus the transaction in
// the window stage fill up. Writing grid width or height restarts the frame.
module cave_automaton_smoothing_pass_core
   import csp_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   csp_req_if.sink                req_chan,
   csp_rsp_if.source              rsp_chan,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic [WIDTH_REG_W-1:0]  width_ff, width_in;
   logic [HEIGHT_REG_W-1:0] height_ff, height_in;
   logic [LIMIT_W-1:0]      birth_ff, birth_in;
   logic [LIMIT_W-1:0]      survival_ff, survival_in;

   logic            restart;
   geom_cfg_type    geom;
   limit_cfg_type   limits;
   stage_item_type  item;
   logic [COL_W-1:0]  rd_addr;
   logic [LINE_W-1:0] rd_data;
   logic              wr_en;
   logic [COL_W-1:0]  wr_addr;
   logic [LINE_W-1:0] wr_data;
   logic              push;
   result_type        push_data;
   logic [QCNT_W-1:0] queue_level;

   always_comb begin
      width_in    = width_ff;
      height_in   = height_ff;
      birth_in    = birth_ff;
      survival_in = survival_ff;
      restart     = 1'b0;
      if (csr_we) begin
         unique case (csr_index)
            REG_GRID_WIDTH: begin
               width_in = csr_wdata[WIDTH_REG_W-1:0];
               restart  = 1'b1;
            end
            REG_GRID_HEIGHT: begin
               height_in = csr_wdata[HEIGHT_REG_W-1:0];
               restart   = 1'b1;
            end
            REG_BIRTH_LIMIT: begin
               birth_in = csr_wdata[LIMIT_W-1:0];
            end
            REG_SURVIVAL_LIMIT: begin
               survival_in = csr_wdata[LIMIT_W-1:0];
            end
            default: begin
            end
         endcase
      end

      if (width_ff == '0) begin
         geom.width = EFF_W_W'(1);
      end else if (int'(width_ff) > MAX_WIDTH) begin
         geom.width = EFF_W_W'(MAX_WIDTH);
      end else begin
         geom.width = EFF_W_W'(width_ff);
      end

      if (height_ff == '0) begin
         geom.height = ROW_CNT_W'(1);
      end else if (int'(height_ff) > HEIGHT_CAP) begin
         geom.height = ROW_CNT_W'(HEIGHT_CAP);
      end else begin
         geom.height = ROW_CNT_W'(height_ff);
      end

      limits.birth    = birth_ff;
      limits.survival = survival_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= WIDTH_RESET;
         height_ff   <= HEIGHT_RESET;
         birth_ff    <= BIRTH_RESET;
         survival_ff <= SURVIVAL_RESET;
      end else begin
         width_ff    <= width_in;
         height_ff   <= height_in;
         birth_ff    <= birth_in;
         survival_ff <= survival_in;
      end
   end

   csp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .geom        (geom),
      .restart     (restart),
      .queue_level (queue_level),
      .item        (item),
      .rd_addr     (rd_addr)
   );

   csp_ram #(
      .WIDTH (LINE_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   csp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .item      (item),
      .limits    (limits),
      .restart   (restart),
      .rd_data   (rd_data),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .push      (push),
      .push_data (push_data)
   );

   csp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .level     (queue_level),
      .rsp_chan  (rsp_chan)
   );

endmodule
